// ----- src/bdfe_pkg.sv -----
// Shared types and constants for the block delta frame encoder.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package bdfe_pkg;

  // Fixed field widths.
  localparam int ByteW  = 8;
  localparam int FrameW = 20;
  localparam int BsizeW = 6;
  // Holds a block length up to the largest block size the 6-bit field gives (63).
  localparam int LenW   = 7;

  localparam int DefMaxBlock      = 32;
  localparam int DefMaxFrameBytes = 524288;

  localparam logic [BsizeW-1:0] BlockSizeRst  = BsizeW'(8);
  localparam logic [FrameW-1:0] FrameBytesRst = FrameW'(288000);

  localparam int MinBlock = 4;
  localparam int MinFrame = 4;
  localparam int OffBytes = 4;

  // Configuration register indexes.
  localparam logic CfgBlockSize  = 1'b0;
  localparam logic CfgFrameBytes = 1'b1;

  // Result kinds.
  localparam logic KindPayload = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] cur_byte;
    logic [ByteW-1:0] prev_byte;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [ByteW-1:0]  out_byte;
    logic [FrameW-1:0] payload_total;
    logic              aborted;
    logic              last;
  } res_t;

  // Work for the back end: one per input word that causes results.
  typedef struct packed {
    logic              has_blk;
    logic              bank;
    logic [FrameW-1:0] start;
    logic [LenW-1:0]   len;
    logic              has_sum;
    logic              sum_aborted;
    logic [FrameW-1:0] total;
  } cmd_t;

  // Back end hands a block buffer back to the front end.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

`default_nettype wire

// ----- src/bdfe_front.sv -----
// Front end: takes input words, fills the block buffers, tracks frame state
// and issues commands. Depends on bdfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdfe_front #(
  parameter int MAX_BLOCK       = bdfe_pkg::DefMaxBlock,
  parameter int MAX_FRAME_BYTES = bdfe_pkg::DefMaxFrameBytes,
  localparam int AW = $clog2(MAX_BLOCK)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire bdfe_pkg::item_t               item_i,
  output logic                               full_o,
  input  wire logic [bdfe_pkg::BsizeW-1:0]   block_size_i,
  input  wire logic [bdfe_pkg::FrameW-1:0]   frame_bytes_i,
  output logic                               st_we_o,
  output logic                               st_bank_o,
  output logic [AW-1:0]                      st_addr_o,
  output logic [bdfe_pkg::ByteW-1:0]         st_data_o,
  output logic                               cmd_push_o,
  output bdfe_pkg::cmd_t                     cmd_o,
  input  wire logic                          cmd_full_i,
  input  wire bdfe_pkg::rel_t                rel_i
);

  localparam int LW = bdfe_pkg::LenW;
  localparam int FW = bdfe_pkg::FrameW;

  logic [AW-1:0] pos_q, pos_d;
  logic [FW-1:0] off_q, off_d;
  logic [FW-1:0] cnt_q, cnt_d;
  logic          diff_q, diff_d;
  logic          ab_q, ab_d;
  logic          bank_q, bank_d;
  logic [1:0]    busy_q, busy_d;

  logic [LW-1:0] bsz, pos1;
  logic [FW:0]   fbx, off1;
  logic [FW-1:0] cnt_new;
  logic          acc, diff, blk_end, emit_blk, abort_now, frame_end, frame_sum;

  // Clamp the configured sizes.
  always_comb begin
    bsz = LW'(block_size_i);
    if (bsz < LW'(bdfe_pkg::MinBlock)) bsz = LW'(bdfe_pkg::MinBlock);
    else if (bsz > LW'(MAX_BLOCK)) bsz = LW'(MAX_BLOCK);
    fbx = {1'b0, frame_bytes_i};
    if (fbx < (FW+1)'(bdfe_pkg::MinFrame)) fbx = (FW+1)'(bdfe_pkg::MinFrame);
    else if (fbx > (FW+1)'(MAX_FRAME_BYTES)) fbx = (FW+1)'(MAX_FRAME_BYTES);
  end

  assign full_o = busy_q[bank_q] | cmd_full_i;
  assign acc    = push_i & ~full_o;

  always_comb begin
    pos1      = LW'(pos_q) + LW'(1);
    off1      = {1'b0, off_q} + (FW+1)'(1);
    diff      = diff_q | (item_i.cur_byte != item_i.prev_byte);
    blk_end   = pos1 >= bsz;
    emit_blk  = blk_end & diff & ~ab_q;
    cnt_new   = cnt_q + FW'(pos1) + FW'(bdfe_pkg::OffBytes);
    abort_now = emit_blk & (cnt_new >= fbx[FW:1]);
    frame_end = off1 >= fbx;
    frame_sum = frame_end & ~ab_q & ~abort_now;
  end

  assign st_we_o   = acc;
  assign st_bank_o = bank_q;
  assign st_addr_o = pos_q;
  assign st_data_o = item_i.cur_byte;

  assign cmd_push_o        = acc & (emit_blk | frame_sum);
  assign cmd_o.has_blk     = emit_blk;
  assign cmd_o.bank        = bank_q;
  assign cmd_o.start       = off1[FW-1:0] - FW'(pos1);
  assign cmd_o.len         = pos1;
  assign cmd_o.has_sum     = abort_now | frame_sum;
  assign cmd_o.sum_aborted = abort_now;
  assign cmd_o.total       = emit_blk ? cnt_new : cnt_q;

  always_comb begin
    pos_d  = pos_q;
    off_d  = off_q;
    cnt_d  = cnt_q;
    diff_d = diff_q;
    ab_d   = ab_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (rel_i.valid) busy_d[rel_i.bank] = 1'b0;
    if (acc) begin
      if (emit_blk) begin
        busy_d[bank_q] = 1'b1;
        bank_d         = ~bank_q;
      end
      if (frame_end) begin
        pos_d  = '0;
        off_d  = '0;
        cnt_d  = '0;
        diff_d = 1'b0;
        ab_d   = 1'b0;
      end else begin
        off_d  = off1[FW-1:0];
        pos_d  = blk_end ? '0 : pos1[AW-1:0];
        diff_d = blk_end ? 1'b0 : diff;
        cnt_d  = emit_blk ? cnt_new : cnt_q;
        ab_d   = ab_q | abort_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      off_q  <= '0;
      cnt_q  <= '0;
      diff_q <= 1'b0;
      ab_q   <= 1'b0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      pos_q  <= pos_d;
      off_q  <= off_d;
      cnt_q  <= cnt_d;
      diff_q <= diff_d;
      ab_q   <= ab_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/bdfe_cmd_fifo.sv -----
// Two-entry command queue between the front and back ends.
// Depends on bdfe_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module bdfe_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bdfe_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  output logic                 valid_o,
  output bdfe_pkg::cmd_t       cmd_o,
  input  wire logic            pop_i
);

  bdfe_pkg::cmd_t entry_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = entry_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/bdfe_back.sv -----
// Back end: holds the two block buffers and plays out each command as
// payload words and summaries into the output register. Depends on bdfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdfe_back #(
  parameter int MAX_BLOCK = bdfe_pkg::DefMaxBlock,
  localparam int AW = $clog2(MAX_BLOCK)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   st_we_i,
  input  wire logic                   st_bank_i,
  input  wire logic [AW-1:0]          st_addr_i,
  input  wire logic [bdfe_pkg::ByteW-1:0] st_data_i,
  input  wire logic                   cmd_valid_i,
  input  wire bdfe_pkg::cmd_t         cmd_i,
  output logic                        cmd_pop_o,
  output bdfe_pkg::rel_t              rel_o,
  input  wire logic                   pop_i,
  output logic                        empty_o,
  output bdfe_pkg::res_t              res_o
);

  localparam int SW = $clog2(MAX_BLOCK + 6);
  localparam int BW = bdfe_pkg::ByteW;

  logic [BW-1:0] mem [2][MAX_BLOCK];
  logic [BW-1:0] rd_q;
  logic [SW-1:0] step_q, step_d, nsteps, rd_step;
  logic [AW-1:0] rd_idx;
  logic          ovalid_q, ovalid_d;
  bdfe_pkg::res_t out_q, out_d;
  logic          fire, is_last;

  always_ff @(posedge clk_i) begin
    if (st_we_i) mem[st_bank_i][st_addr_i] <= st_data_i;
  end

  always_comb begin
    nsteps = SW'(cmd_i.has_sum);
    if (cmd_i.has_blk) nsteps = nsteps + SW'(cmd_i.len) + SW'(bdfe_pkg::OffBytes);
    is_last = step_q == nsteps - SW'(1);
    fire    = cmd_valid_i & (~ovalid_q | pop_i);
    step_d  = step_q;
    if (fire) step_d = is_last ? '0 : step_q + SW'(1);
    // Fetch the byte for the step shown next.
    rd_step = step_d - SW'(bdfe_pkg::OffBytes);
    rd_idx  = rd_step[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[cmd_i.bank][rd_idx];
  end

  always_comb begin
    out_d.kind          = bdfe_pkg::KindSummary;
    out_d.out_byte      = '0;
    out_d.payload_total = cmd_i.total;
    out_d.aborted       = cmd_i.sum_aborted;
    out_d.last          = is_last;
    if (cmd_i.has_blk && step_q < SW'(cmd_i.len) + SW'(bdfe_pkg::OffBytes)) begin
      out_d.kind          = bdfe_pkg::KindPayload;
      out_d.payload_total = '0;
      out_d.aborted       = 1'b0;
      case (step_q)
        SW'(0):  out_d.out_byte = cmd_i.start[7:0];
        SW'(1):  out_d.out_byte = cmd_i.start[15:8];
        SW'(2):  out_d.out_byte = BW'(cmd_i.start[bdfe_pkg::FrameW-1:16]);
        SW'(3):  out_d.out_byte = '0;
        default: out_d.out_byte = rd_q;
      endcase
    end
    ovalid_d = fire | (ovalid_q & ~pop_i);
  end

  assign cmd_pop_o   = fire & is_last;
  assign rel_o.valid = fire & is_last & cmd_i.has_blk;
  assign rel_o.bank  = cmd_i.bank;
  assign empty_o     = ~ovalid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/block_delta_frame_encoder.sv -----
// Block delta frame encoder: configuration registers, front end, command
// queue and back end. Depends on bdfe_pkg and the bdfe_* submodules.
//
// Input side is a queue: drive item_i and raise push; the word is taken at
// a clock edge with push high and full low. Results form a queue too: while
// empty is low, res_o holds the oldest result; raise pop to take it.
// Configuration words arrive on cfg_valid_i/cfg_index_i/cfg_data_i and are
// always taken (cfg_ready_o is high); write them only while the block is idle.
// The front end takes one byte per cycle into one of two block buffers. When
// a changed block ends, the back end plays it out as 4 offset bytes plus the
// block bytes, one result per cycle, while the front end fills the other
// buffer. Intake stalls when both buffers wait for the back end or the
// command queue is full, so a frame with every block changed is paced by the
// back end; unchanged blocks cost one cycle per byte while intake runs free.
// The first result of a block goes through the command queue and the output
// register after its last byte is taken.
// Reset clears the frame position, totals and queues; buffer contents are
// not cleared. A stalled receiver backs up the output register, then the
// command queue, then the input.
`timescale 1ns / 1ps
`default_nettype none

module block_delta_frame_encoder #(
  parameter int MAX_BLOCK       = bdfe_pkg::DefMaxBlock,
  parameter int MAX_FRAME_BYTES = bdfe_pkg::DefMaxFrameBytes
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire bdfe_pkg::item_t              item_i,
  output logic                              empty,
  input  wire logic                         pop,
  output bdfe_pkg::res_t                    res_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_index_i,
  input  wire logic [bdfe_pkg::FrameW-1:0]  cfg_data_i
);

  localparam int AW = $clog2(MAX_BLOCK);

  logic [bdfe_pkg::BsizeW-1:0] block_size_q;
  logic [bdfe_pkg::FrameW-1:0] frame_bytes_q;

  logic                       st_we, st_bank;
  logic [AW-1:0]              st_addr;
  logic [bdfe_pkg::ByteW-1:0] st_data;
  logic                       cmd_push, cmd_full, cmd_valid, cmd_pop;
  bdfe_pkg::cmd_t             cmd_in, cmd_head;
  bdfe_pkg::rel_t             rel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= bdfe_pkg::BlockSizeRst;
      frame_bytes_q <= bdfe_pkg::FrameBytesRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bdfe_pkg::CfgBlockSize:  block_size_q  <= cfg_data_i[bdfe_pkg::BsizeW-1:0];
        bdfe_pkg::CfgFrameBytes: frame_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bdfe_front #(
    .MAX_BLOCK       (MAX_BLOCK),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .item_i        (item_i),
    .full_o        (full),
    .block_size_i  (block_size_q),
    .frame_bytes_i (frame_bytes_q),
    .st_we_o       (st_we),
    .st_bank_o     (st_bank),
    .st_addr_o     (st_addr),
    .st_data_o     (st_data),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in),
    .cmd_full_i    (cmd_full),
    .rel_i         (rel)
  );

  bdfe_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head),
    .pop_i   (cmd_pop)
  );

  bdfe_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_we_i     (st_we),
    .st_bank_i   (st_bank),
    .st_addr_i   (st_addr),
    .st_data_i   (st_data),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .rel_o       (rel),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking bench for block_delta_frame_encoder: walks a directed table and then
// random phases, and checks result words against a behavioral encoder model or typed sums.
// Depends on bdfe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb;

  localparam int CycLimit = 400000;
  localparam int Settle   = 16;
  localparam int RxHold   = 400;

  typedef enum logic {RowCfg, RowByte} row_op_e;
  typedef enum logic [1:0] {ChkModel, ChkNone, ChkSum} row_chk_e;

  typedef struct packed {
    row_op_e                     op;
    logic                        idx;
    logic [bdfe_pkg::FrameW-1:0] data;
    logic [bdfe_pkg::ByteW-1:0]  cur;
    logic [bdfe_pkg::ByteW-1:0]  prev;
    row_chk_e                    chk;
    logic [bdfe_pkg::FrameW-1:0] tot;
    logic                        ab;
  } row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        push;
  logic                        full;
  bdfe_pkg::item_t             item;
  logic                        empty;
  logic                        pop;
  bdfe_pkg::res_t              res;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic                        cfg_index_i;
  logic [bdfe_pkg::FrameW-1:0] cfg_data_i;

  // Encoder model state and its copy of the registers
  logic [bdfe_pkg::ByteW-1:0]  blk_buf [bdfe_pkg::DefMaxBlock];
  int unsigned                 frm_off;
  int unsigned                 blk_pos;
  int unsigned                 pay_cnt;
  bit                          blk_dirty;
  bit                          frm_abort;
  logic [bdfe_pkg::BsizeW-1:0] cur_bsize;
  logic [bdfe_pkg::FrameW-1:0] cur_fbytes;

  bdfe_pkg::res_t step_res [$];
  bdfe_pkg::res_t encoded_q [$];
  row_t           dir_tab [$];
  bdfe_pkg::res_t chk_want;
  int   n_err;
  int   idle_pct;
  int   stall_pct;
  int   hold_seq;
  int   hold_seen;
  int   hold_cnt;
  int   cyc_cnt;

  block_delta_frame_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bdfe_pkg::res_t mk_res(logic kd, logic [bdfe_pkg::ByteW-1:0] b,
                                            logic [bdfe_pkg::FrameW-1:0] t,
                                            logic a, logic lst);
    bdfe_pkg::res_t r;
    r.kind          = kd;
    r.out_byte      = b;
    r.payload_total = t;
    r.aborted       = a;
    r.last          = lst;
    return r;
  endfunction

  function automatic row_t cfg_row(logic idx, logic [bdfe_pkg::FrameW-1:0] data);
    return '{RowCfg, idx, data, 8'h00, 8'h00, ChkNone, '0, 1'b0};
  endfunction

  function automatic row_t byte_row(logic [bdfe_pkg::ByteW-1:0] c,
                                    logic [bdfe_pkg::ByteW-1:0] p, row_chk_e chk);
    return '{RowByte, bdfe_pkg::CfgBlockSize, '0, c, p, chk, '0, 1'b0};
  endfunction

  function automatic row_t sum_row(logic [bdfe_pkg::ByteW-1:0] c,
                                   logic [bdfe_pkg::ByteW-1:0] p,
                                   logic [bdfe_pkg::FrameW-1:0] t, logic a);
    return '{RowByte, bdfe_pkg::CfgBlockSize, '0, c, p, ChkSum, t, a};
  endfunction

  // Advance the model by one byte and leave the words it causes in step_res.
  function automatic void encode_byte(input bdfe_pkg::item_t it);
    int unsigned    bs;
    int unsigned    fb;
    int unsigned    len;
    int unsigned    start;
    bdfe_pkg::res_t tail;
    bs = (cur_bsize < bdfe_pkg::MinBlock) ? bdfe_pkg::MinBlock :
         (cur_bsize > bdfe_pkg::DefMaxBlock) ? bdfe_pkg::DefMaxBlock : int'(cur_bsize);
    fb = (cur_fbytes < bdfe_pkg::MinFrame) ? bdfe_pkg::MinFrame :
         (cur_fbytes > bdfe_pkg::DefMaxFrameBytes) ? bdfe_pkg::DefMaxFrameBytes :
         int'(cur_fbytes);
    step_res.delete();
    if (blk_pos < bdfe_pkg::DefMaxBlock) blk_buf[blk_pos] = it.cur_byte;
    if (it.cur_byte != it.prev_byte) blk_dirty = 1'b1;
    blk_pos++;
    frm_off++;
    if (blk_pos >= bs) begin
      len = (blk_pos > bdfe_pkg::DefMaxBlock) ? bdfe_pkg::DefMaxBlock : blk_pos;
      if (blk_dirty && !frm_abort) begin
        start = frm_off - len;
        for (int k = 0; k < bdfe_pkg::OffBytes; k++)
          step_res.push_back(mk_res(bdfe_pkg::KindPayload, 8'(start >> (8 * k)), '0,
                                    1'b0, 1'b0));
        for (int k = 0; k < len; k++)
          step_res.push_back(mk_res(bdfe_pkg::KindPayload, blk_buf[k], '0, 1'b0, 1'b0));
        pay_cnt += len + bdfe_pkg::OffBytes;
        if (pay_cnt >= fb / 2) begin
          frm_abort = 1'b1;
          step_res.push_back(mk_res(bdfe_pkg::KindSummary, '0, 20'(pay_cnt), 1'b1, 1'b0));
        end
      end
      blk_pos   = 0;
      blk_dirty = 1'b0;
    end
    if (frm_off >= fb) begin
      if (!frm_abort)
        step_res.push_back(mk_res(bdfe_pkg::KindSummary, '0, 20'(pay_cnt), 1'b0, 1'b0));
      frm_off   = 0;
      blk_pos   = 0;
      blk_dirty = 1'b0;
      pay_cnt   = 0;
      frm_abort = 1'b0;
    end
    if (step_res.size() > 0) begin
      tail      = step_res.pop_back();
      tail.last = 1'b1;
      step_res.push_back(tail);
    end
  endfunction

  function automatic bdfe_pkg::item_t mk_item(input int diff_pct);
    bdfe_pkg::item_t it;
    it.cur_byte  = 8'($urandom);
    it.prev_byte = it.cur_byte;
    if (diff_pct < 100 && $urandom_range(9) == 0) it.prev_byte = 8'($urandom);
    else if ($urandom_range(99) < diff_pct)
      it.prev_byte = it.cur_byte ^ 8'($urandom_range(1, 255));
    return it;
  endfunction

  task automatic send_byte(input bdfe_pkg::item_t it, input row_chk_e chk,
                           input bdfe_pkg::res_t typed);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk_i); while (full);
    encode_byte(it);
    case (chk)
      ChkModel: foreach (step_res[k]) encoded_q.push_back(step_res[k]);
      ChkSum:   encoded_q.push_back(typed);
      default:  ;
    endcase
  endtask

  // Drop push and hold until the block has nothing left to deliver.
  task automatic wait_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (encoded_q.size() != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [bdfe_pkg::FrameW-1:0] val);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == bdfe_pkg::CfgBlockSize) cur_bsize = val[bdfe_pkg::BsizeW-1:0];
    else cur_fbytes = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    pop      = 1'b0;
    hold_cnt = RxHold;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_cnt  = 0;
      end
      if (hold_cnt < RxHold) begin
        hold_cnt++;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (encoded_q.size() == 0) begin
        $display("%0t: unexpected word: kind %0d byte %02h total %0d aborted %0d last %0d",
                 $time, res.kind, res.out_byte, res.payload_total, res.aborted, res.last);
        n_err++;
      end else begin
        chk_want = encoded_q.pop_front();
        if (res.kind !== chk_want.kind || res.out_byte !== chk_want.out_byte ||
            res.payload_total !== chk_want.payload_total ||
            res.aborted !== chk_want.aborted || res.last !== chk_want.last) begin
          $display("%0t: mismatch: expected kind %0d byte %02h total %0d aborted %0d last %0d",
                   $time, chk_want.kind, chk_want.out_byte, chk_want.payload_total,
                   chk_want.aborted, chk_want.last);
          $display("%0t:           actual kind %0d byte %02h total %0d aborted %0d last %0d",
                   $time, res.kind, res.out_byte, res.payload_total, res.aborted, res.last);
          n_err++;
        end
      end
    end
  end

  initial begin
    cyc_cnt = 0;
    while (cyc_cnt < CycLimit) begin
      @(posedge clk_i);
      cyc_cnt++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    int unsigned                 r;
    int unsigned                 eff;
    int unsigned                 n;
    logic [bdfe_pkg::FrameW-1:0] bs_w;
    logic [bdfe_pkg::FrameW-1:0] fb_w;
    bit                          chg;
    row_t                        rw;

    rst_ni      = 1'b0;
    push        = 1'b0;
    item        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = bdfe_pkg::CfgBlockSize;
    cfg_data_i  = '0;
    n_err       = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_seq    = 0;
    hold_seen   = 0;
    cur_bsize   = bdfe_pkg::BlockSizeRst;
    cur_fbytes  = bdfe_pkg::FrameBytesRst;
    frm_off     = 0;
    blk_pos     = 0;
    pay_cnt     = 0;
    blk_dirty   = 1'b0;
    frm_abort   = 1'b0;

    // Block size below range, unchanged block, partial block dropped at frame end
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgBlockSize, 20'd0));
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgFrameBytes, 20'd6));
    dir_tab.push_back(byte_row(8'h00, 8'h00, ChkNone));
    dir_tab.push_back(byte_row(8'hFF, 8'hFF, ChkNone));
    dir_tab.push_back(byte_row(8'h00, 8'h00, ChkNone));
    dir_tab.push_back(byte_row(8'h5A, 8'h5A, ChkNone));
    dir_tab.push_back(byte_row(8'hFF, 8'h00, ChkNone));
    dir_tab.push_back(sum_row(8'h00, 8'hFF, 20'd0, 1'b0));
    // Frame size below range, abort on the frame's last block; upper data bits ignored
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgFrameBytes, 20'd1));
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgBlockSize, 20'hFFFC4));
    dir_tab.push_back(byte_row(8'hFF, 8'h00, ChkModel));
    dir_tab.push_back(byte_row(8'h00, 8'hFF, ChkModel));
    dir_tab.push_back(byte_row(8'hA5, 8'h5A, ChkModel));
    dir_tab.push_back(byte_row(8'h80, 8'h01, ChkModel));
    // Abort mid-frame, then the rest of the frame stays silent
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgFrameBytes, 20'd8));
    dir_tab.push_back(byte_row(8'h01, 8'h02, ChkModel));
    dir_tab.push_back(byte_row(8'h7F, 8'h80, ChkModel));
    dir_tab.push_back(byte_row(8'hFE, 8'hFF, ChkModel));
    dir_tab.push_back(byte_row(8'h10, 8'h10, ChkModel));
    dir_tab.push_back(byte_row(8'hC3, 8'h3C, ChkNone));
    dir_tab.push_back(byte_row(8'h3C, 8'hC3, ChkNone));
    dir_tab.push_back(byte_row(8'hFF, 8'h00, ChkNone));
    dir_tab.push_back(byte_row(8'h00, 8'hFF, ChkNone));
    // Both sizes above range, then shrunk mid-block and mid-frame
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgBlockSize, 20'd63));
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgFrameBytes, 20'hFFFFF));
    dir_tab.push_back(byte_row(8'h11, 8'h11, ChkNone));
    dir_tab.push_back(byte_row(8'h22, 8'h22, ChkNone));
    dir_tab.push_back(byte_row(8'h33, 8'h33, ChkNone));
    dir_tab.push_back(byte_row(8'h44, 8'h44, ChkNone));
    dir_tab.push_back(byte_row(8'h55, 8'h55, ChkNone));
    dir_tab.push_back(byte_row(8'h66, 8'h67, ChkNone));
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgBlockSize, 20'd4));
    dir_tab.push_back(byte_row(8'h77, 8'h77, ChkModel));
    dir_tab.push_back(cfg_row(bdfe_pkg::CfgFrameBytes, 20'd8));
    dir_tab.push_back(sum_row(8'h88, 8'h88, 20'd11, 1'b0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      rw = dir_tab[i];
      if (rw.op == RowCfg) begin
        write_cfg(rw.idx, rw.data);
      end else begin
        send_byte('{cur_byte: rw.cur, prev_byte: rw.prev}, rw.chk,
                  mk_res(bdfe_pkg::KindSummary, '0, rw.tot, rw.ab, 1'b1));
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 23 : 0;
      stall_pct = (ph == 2) ? 84 : (ph == 3) ? 23 : 0;
      r    = $urandom_range(7);
      bs_w = (r < 5) ? 20'(4 * $urandom_range(1, 2)) :
             (r == 5) ? 20'd32 : 20'($urandom_range(0, 63));
      eff  = (bs_w < bdfe_pkg::MinBlock) ? bdfe_pkg::MinBlock :
             (bs_w > bdfe_pkg::DefMaxBlock) ? bdfe_pkg::DefMaxBlock : bs_w;
      if ($urandom_range(3) == 0) fb_w = 20'($urandom_range(64, 2000));
      else fb_w = 20'(eff * $urandom_range(2, 6) + (($urandom_range(2) == 0) ?
                      $urandom_range(1, 3) : 0));
      bs_w = {(($urandom_range(3) == 0) ? 14'($urandom) : 14'd0),
              bs_w[bdfe_pkg::BsizeW-1:0]};
      if ($urandom_range(1) == 1) begin
        write_cfg(bdfe_pkg::CfgBlockSize, bs_w);
        write_cfg(bdfe_pkg::CfgFrameBytes, fb_w);
      end else begin
        write_cfg(bdfe_pkg::CfgFrameBytes, fb_w);
        write_cfg(bdfe_pkg::CfgBlockSize, bs_w);
      end
      n   = $urandom_range(8, 12) + ((eff >= 16) ? eff : 0);
      chg = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (k % eff == 0) chg = ($urandom_range(99) < 45);
        // hold the sender until everything owed has come out
        if (ph == 0 && k == n / 2) wait_drain();
        send_byte(mk_item(chg ? 35 : 0), ChkModel, '0);
      end
    end

    // Stall the result side long enough for the block to back up into full
    idle_pct  = 0;
    stall_pct = 0;
    write_cfg(bdfe_pkg::CfgBlockSize, 20'd4);
    write_cfg(bdfe_pkg::CfgFrameBytes, 20'd1000);
    hold_seq++;
    for (int k = 0; k < 24; k++) send_byte(mk_item(100), ChkModel, '0);

    wait_drain();
    if (n_err == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bdfe_pkg.sv
src/bdfe_front.sv
src/bdfe_cmd_fifo.sv
src/bdfe_back.sv
src/block_delta_frame_encoder.sv
dv/tb.sv
